>>> src/iorob_pkg.sv
// Package for the in-order reorder buffer: word types, status codes,
// controller states and the command/status bundles between controller and datapath.
// No dependencies.
package iorob_pkg;

	// Input word: one completed frame
	typedef struct packed {
		logic [31:0] seq_id;
		logic [63:0] payload;
	} in_word_t;

	// Result status codes
	typedef enum logic [1:0] {
		STATUS_RELEASED  = 2'd0,
		STATUS_STALE     = 2'd1,
		STATUS_DUPLICATE = 2'd2,
		STATUS_BEYOND    = 2'd3
	} status_t;

	// Output word: one released or rejected frame
	typedef struct packed {
		logic [31:0] out_seq_id;
		logic [63:0] out_payload;
		status_t     status;
		logic        last;
	} out_word_t;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_READ,
		ST_LOAD,
		ST_OUT
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;      // capture the incoming frame word
		logic classify;     // fix the expected id on the first frame
		logic load_reject;  // load the result register with a reject word
		logic park;         // write the frame into its slot
		logic read_head;    // read the slot at the window head
		logic release_head; // emit head slot, advance window, prefetch next
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic reject;   // captured frame cannot be parked
		logic off_zero; // captured frame lands on the window head
		logic last;     // result register holds the final word of this frame
	} dp_sts_t;

endpackage

>>> src/iorob_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module iorob_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

>>> src/iorob_ctrl.sv
// Controller state machine for the in-order reorder buffer.
// Depends on iorob_pkg.
module iorob_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              frame_valid,
	output logic              frame_stall,
	output logic              result_valid,
	input  logic              result_stall,
	output iorob_pkg::dp_cmd_t cmd,
	input  iorob_pkg::dp_sts_t sts
);

	import iorob_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		frame_stall  = 1'b1;
		result_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				frame_stall = 1'b0;
				if (frame_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.classify = 1'b1;
				if (sts.reject) begin
					cmd.load_reject = 1'b1;
					state_d         = ST_OUT;
				end else begin
					cmd.park = 1'b1;
					state_d  = sts.off_zero ? ST_READ : ST_IDLE;
				end
			end
			ST_READ: begin
				cmd.read_head = 1'b1;
				state_d       = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.release_head = 1'b1;
				state_d          = ST_OUT;
			end
			ST_OUT: begin
				result_valid = 1'b1;
				if (!result_stall) begin
					if (sts.last) begin
						state_d = ST_IDLE;
					end else begin
						// next slot was prefetched: load it while the word drains
						cmd.release_head = 1'b1;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

>>> src/iorob_dp.sv
// Datapath for the in-order reorder buffer: window head, slot valid bits,
// expected id, slot payload RAM and the result register.
// Depends on iorob_pkg and iorob_ram.
module iorob_dp #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iorob_pkg::in_word_t  frame,
	output iorob_pkg::out_word_t result,
	input  iorob_pkg::dp_cmd_t   cmd,
	output iorob_pkg::dp_sts_t   sts
);

	import iorob_pkg::*;

	localparam int IW = $clog2(WINDOW_DEPTH);

	in_word_t                frame_q;
	out_word_t               result_q;
	logic [31:0]             expected_q;
	logic                    known_q;
	logic [IW-1:0]           head_q;
	logic [WINDOW_DEPTH-1:0] valid_q;

	logic [31:0]   exp_eff;
	logic [31:0]   off;
	logic          stale;
	logic          beyond;
	logic          dup;
	logic [IW:0]   slot_sum;
	logic [IW-1:0] slot_idx;
	logic [IW-1:0] head_plus1;
	logic [63:0]   rd_data;
	status_t       rej_code;

	// offset of the captured frame from the expected id
	assign exp_eff = known_q ? expected_q : frame_q.seq_id;
	assign off     = frame_q.seq_id - exp_eff;
	assign stale   = off[31];
	assign beyond  = !stale && (off >= 32'(WINDOW_DEPTH));

	// slot = head + offset, wrapped at the window depth
	assign slot_sum = {1'b0, head_q} + {1'b0, off[IW-1:0]};
	assign slot_idx = (slot_sum >= (IW+1)'(WINDOW_DEPTH)) ?
		IW'(slot_sum - (IW+1)'(WINDOW_DEPTH)) : slot_sum[IW-1:0];
	assign head_plus1 = (head_q == IW'(WINDOW_DEPTH - 1)) ? '0 : head_q + IW'(1);

	assign dup = !stale && !beyond && valid_q[slot_idx];

	always_comb begin
		if (stale) begin
			rej_code = STATUS_STALE;
		end else if (beyond) begin
			rej_code = STATUS_BEYOND;
		end else begin
			rej_code = STATUS_DUPLICATE;
		end
	end

	assign sts.reject   = stale || beyond || dup;
	assign sts.off_zero = (off == 32'd0);
	assign sts.last     = result_q.last;

	iorob_ram #(
		.WIDTH(64),
		.DEPTH(WINDOW_DEPTH)
	) u_slot_ram (
		.clk    (clk),
		.wr_en  (cmd.park),
		.wr_addr(slot_idx),
		.wr_data(frame_q.payload),
		.rd_en  (cmd.read_head || cmd.release_head),
		.rd_addr(cmd.release_head ? head_plus1 : head_q),
		.rd_data(rd_data)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_q <= '0;
			known_q    <= 1'b0;
			head_q     <= '0;
			valid_q    <= '0;
		end else begin
			if (cmd.classify && !known_q) begin
				expected_q <= frame_q.seq_id;
				known_q    <= 1'b1;
			end
			if (cmd.park) begin
				valid_q[slot_idx] <= 1'b1;
			end
			if (cmd.release_head) begin
				valid_q[head_q] <= 1'b0;
				head_q          <= head_plus1;
				expected_q      <= expected_q + 32'd1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			frame_q <= frame;
		end
		if (cmd.load_reject) begin
			result_q.out_seq_id  <= frame_q.seq_id;
			result_q.out_payload <= frame_q.payload;
			result_q.status      <= rej_code;
			result_q.last        <= 1'b1;
		end else if (cmd.release_head) begin
			result_q.out_seq_id  <= expected_q;
			result_q.out_payload <= rd_data;
			result_q.status      <= STATUS_RELEASED;
			result_q.last        <= !valid_q[head_plus1];
		end
	end

	assign result = result_q;

endmodule

>>> src/in_order_reorder_buffer_unit.sv
// Top level of the in-order reorder buffer: controller plus datapath.
// Depends on iorob_pkg, iorob_ctrl, iorob_dp (and iorob_ram through iorob_dp).
//
//  channel  | handshake                   | word
//  ---------+-----------------------------+------------------------------------
//  frame    | frame_valid / frame_stall   | in_word_t: seq_id, payload
//  result   | result_valid / result_stall | out_word_t: id, payload, status, last
//
// A frame that is parked or rejected goes through capture and classify; a reject
// then waits in the result register. A frame that completes the run at the expected
// id then reads the head slot out of the payload RAM (read, load) and emits one
// released word per cycle while the result side does not stall, since the next
// slot is prefetched while the current word drains.
// Reset clears the valid bits, head and expected id at once; no clearing pass.
// A stall on the result side holds the result register and the head pointer;
// the frame side stalls from capture until the frame is parked or its last word is taken.
module in_order_reorder_buffer_unit #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	output logic                 frame_stall,
	input  iorob_pkg::in_word_t  frame,
	output logic                 result_valid,
	input  logic                 result_stall,
	output iorob_pkg::out_word_t result
);

	import iorob_pkg::*;

	dp_cmd_t cmd;
	dp_sts_t sts;

	// sequence the capture, classify, park and release steps
	iorob_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.frame_valid (frame_valid),
		.frame_stall (frame_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.cmd         (cmd),
		.sts         (sts)
	);

	// hold the window, the expected id and the result register
	iorob_dp #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.frame (frame),
		.result(result),
		.cmd   (cmd),
		.sts   (sts)
	);

endmodule

>>> tb/sv/iorob_release_check.sv
// Release-order checker for the in-order reorder buffer: watches both channels,
// predicts every result word from accepted frame words and compares them in order.
// Depends on iorob_pkg.
`timescale 1ns / 100ps

module iorob_release_check #(
	parameter int WINDOW_DEPTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 frame_valid,
	input  logic                 frame_stall,
	input  iorob_pkg::in_word_t  frame,
	input  logic                 result_valid,
	input  logic                 result_stall,
	input  iorob_pkg::out_word_t result,
	output int                   mismatches,
	output int                   outstanding
);
	import iorob_pkg::*;

	localparam int MAX_PRINT = 40;

	logic        shadow_valid   [WINDOW_DEPTH];
	logic [63:0] shadow_payload [WINDOW_DEPTH];
	logic [31:0] head_id;
	logic        head_known;
	out_word_t   pending_words [$];

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINT) begin
			$display("[%0t] MISMATCH: %s", $time, msg);
		end
		mismatches++;
	endtask

	function automatic out_word_t make_word(input logic [31:0] id, input logic [63:0] pay,
			input status_t st, input logic lst);
		out_word_t w;
		w.out_seq_id  = id;
		w.out_payload = pay;
		w.status      = st;
		w.last        = lst;
		return w;
	endfunction

	// Append one predicted word at the tail of the queue.
	function automatic void add_word(input out_word_t w);
		pending_words.insert(pending_words.size(), w);
	endfunction

	// Reject the frame, or park it and release the run at the window head.
	task automatic predict_release(input in_word_t w);
		logic [31:0] off;
		logic [31:0] rel_id;
		logic [63:0] rel_pay;
		int          n;
		if (!head_known) begin
			head_id    = w.seq_id;
			head_known = 1'b1;
		end
		off = w.seq_id - head_id;
		if (off[31]) begin
			add_word(make_word(w.seq_id, w.payload, STATUS_STALE, 1'b1));
		end else if (off >= 32'(WINDOW_DEPTH)) begin
			add_word(make_word(w.seq_id, w.payload, STATUS_BEYOND, 1'b1));
		end else if (shadow_valid[off]) begin
			add_word(make_word(w.seq_id, w.payload, STATUS_DUPLICATE, 1'b1));
		end else begin
			shadow_valid[off]   = 1'b1;
			shadow_payload[off] = w.payload;
			n = 0;
			while (n < WINDOW_DEPTH && shadow_valid[0]) begin
				rel_id  = head_id;
				rel_pay = shadow_payload[0];
				for (int i = 0; i + 1 < WINDOW_DEPTH; i++) begin
					shadow_valid[i]   = shadow_valid[i + 1];
					shadow_payload[i] = shadow_payload[i + 1];
				end
				shadow_valid[WINDOW_DEPTH - 1] = 1'b0;
				head_id = head_id + 32'd1;
				n++;
				add_word(make_word(rel_id, rel_pay, STATUS_RELEASED,
					(n == WINDOW_DEPTH) || !shadow_valid[0]));
			end
		end
	endtask

	task automatic check_result(input out_word_t got);
		out_word_t exp;
		if (pending_words.size() == 0) begin
			report_mismatch($sformatf("unexpected word id=%h status=%0d",
				got.out_seq_id, got.status));
			return;
		end
		exp = pending_words.pop_front();
		if (got.out_seq_id !== exp.out_seq_id)
			report_mismatch($sformatf("frame id %h, want %h",
				got.out_seq_id, exp.out_seq_id));
		if (got.out_payload !== exp.out_payload)
			report_mismatch($sformatf("payload %h, want %h (id %h)",
				got.out_payload, exp.out_payload, exp.out_seq_id));
		if (got.status !== exp.status)
			report_mismatch($sformatf("status %0d, want %0d (id %h)",
				got.status, exp.status, exp.out_seq_id));
		if (got.last !== exp.last)
			report_mismatch($sformatf("last %b, want %b (id %h)",
				got.last, exp.last, exp.out_seq_id));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				shadow_valid[i]   = 1'b0;
				shadow_payload[i] = '0;
			end
			head_id    = '0;
			head_known = 1'b0;
			pending_words.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (frame_valid && !frame_stall) begin
				predict_release(frame);
			end
			if (result_valid && !result_stall) begin
				check_result(result);
			end
			outstanding = pending_words.size();
		end
	end

endmodule

>>> tb/sv/testbench.sv
// Top of the in-order reorder buffer testbench: clock, reset, frame stimulus,
// result-side stall pattern, watchdog and verdict.
// Depends on iorob_pkg, in_order_reorder_buffer_unit and iorob_release_check.
`timescale 1ns / 100ps

module testbench;
	import iorob_pkg::*;

	localparam int WINDOW_DEPTH = 16;
	localparam int RANDOM_ITEMS = 354;
	// Margin to wait for stray words after every predicted word is out.
	localparam int DRAIN_CYCLES = 4 * (4 + WINDOW_DEPTH);
	localparam int CYCLE_LIMIT  = 400000;
	// Long receiver hold-off: starts mid-run, lasts long enough to back up the input.
	localparam int HOLD_START   = 400;
	localparam int HOLD_LEN     = 500;

	logic      clk = 1'b0;
	logic      arst_n;
	logic      frame_valid;
	logic      frame_stall;
	in_word_t  frame;
	logic      result_valid;
	logic      result_stall;
	out_word_t result;
	int        mismatches;
	int        outstanding;

	// Sender state: words left in the current burst, words accepted so far.
	int burst_left;
	int items_sent;

	always #5 clk = ~clk;

	in_order_reorder_buffer_unit #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame        (frame),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	iorob_release_check #(
		.WINDOW_DEPTH(WINDOW_DEPTH)
	) i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.frame_valid  (frame_valid),
		.frame_stall  (frame_stall),
		.frame        (frame),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	// Offer one frame word and hold it until the block takes it. Between bursts,
	// drop valid for a random gap (possibly zero, so bursts can run back to back).
	task automatic send_word(input logic [31:0] id, input logic [63:0] pay);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 12);
			repeat (gap) begin
				@(negedge clk);
				frame_valid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		@(negedge clk);
		frame       <= '{seq_id: id, payload: pay};
		frame_valid <= 1'b1;
		// Hold the word while stalled; it is taken at the first edge with no stall.
		do @(posedge clk); while (frame_stall);
		burst_left--;
		items_sent++;
	endtask

	// Frame stimulus: reset, a directed pass over the special cases, then
	// shuffled in-window sequences with stale, duplicate and far-off noise.
	initial begin : stimulus
		logic [31:0] base;
		logic [31:0] order [WINDOW_DEPTH];
		logic [31:0] tmp;
		int          n;
		int          pick;
		int          start;

		arst_n      = 1'b0;
		frame_valid = 1'b0;
		frame       = '0;
		burst_left  = 0;
		items_sent  = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// First frame fixes the expected id just below the wrap point; it goes
		// straight out with an all-ones handle.
		base = 32'hFFFF_FFFA;
		send_word(base, '1);
		base = base + 32'd1;

		// Stale: one behind, and exactly half the id space away.
		send_word(base - 32'd1, '0);
		send_word(base + 32'h8000_0000, {$urandom, $urandom});
		// Beyond the window: first offset past it and the largest forward offset.
		send_word(base + 32'(WINDOW_DEPTH), {$urandom, $urandom});
		send_word(base + 32'h7FFF_FFFF, {$urandom, $urandom});

		// Park out of order without release, hit a duplicate, then fill the head.
		send_word(base + 32'd3, {$urandom, $urandom});
		send_word(base + 32'd1, {$urandom, $urandom});
		send_word(base + 32'd2, '0);
		send_word(base + 32'd2, '1);
		send_word(base, {$urandom, $urandom});
		base = base + 32'd4;

		// Full window, last slot first, then the head: one run of WINDOW_DEPTH
		// words that crosses the id wrap.
		for (int k = WINDOW_DEPTH - 1; k >= 1; k--) begin
			send_word(base + 32'(k), {$urandom, $urandom});
		end
		send_word(base, {$urandom, $urandom});
		base = base + 32'(WINDOW_DEPTH);

		// Random part. The expected id in the block stays within
		// [base, base + n] during a sequence, which keeps the noise offsets safe.
		start = items_sent;
		while (items_sent - start < RANDOM_ITEMS) begin
			n = ($urandom_range(0, 7) == 0) ? WINDOW_DEPTH : $urandom_range(1, 8);
			for (int j = 0; j < n; j++) begin
				order[j] = base + 32'(j);
			end
			for (int j = n - 1; j >= 1; j--) begin
				pick        = $urandom_range(0, j);
				tmp         = order[j];
				order[j]    = order[pick];
				order[pick] = tmp;
			end
			for (int j = 0; j < n; j++) begin
				send_word(order[j], {$urandom, $urandom});
				if ($urandom_range(0, 5) == 0) begin
					case ($urandom_range(0, 4))
						0: send_word(base - 32'd1 - $urandom_range(0, 40),
							{$urandom, $urandom});
						1: send_word(base - 32'd1 - $urandom_range(0, 32'h7FFF_FF00),
							{$urandom, $urandom});
						// Resend: duplicate if still parked, stale if already out.
						2: send_word(order[$urandom_range(0, j)], {$urandom, $urandom});
						3: send_word(base + 32'd32 + $urandom_range(0, 32'h7FFF_FF00),
							{$urandom, $urandom});
						default: send_word($urandom, {$urandom, $urandom});
					endcase
				end
			end
			base = base + 32'(n);
		end

		@(negedge clk);
		frame_valid <= 1'b0;

		// Drain: wait for every predicted word, then a margin for strays.
		while (outstanding != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Result-side stall pattern: segments of random length, each with its own
	// stall density (from none to heavy), plus one long hold-off counted here.
	initial begin : result_receiver
		int seg_len;
		int stall_pct;
		int rx_cycles;
		bit hold_done;

		result_stall = 1'b0;
		rx_cycles    = 0;
		hold_done    = 1'b0;
		@(posedge arst_n);
		forever begin
			seg_len = $urandom_range(1, 40);
			case ($urandom_range(0, 3))
				0:       stall_pct = 0;
				1:       stall_pct = 25;
				2:       stall_pct = 50;
				default: stall_pct = 90;
			endcase
			repeat (seg_len) begin
				@(negedge clk);
				rx_cycles++;
				if (!hold_done && rx_cycles >= HOLD_START) begin
					// Hold off the result side; the frame side keeps offering.
					result_stall <= 1'b1;
					repeat (HOLD_LEN - 1) begin
						@(negedge clk);
						result_stall <= 1'b1;
					end
					hold_done = 1'b1;
				end else begin
					result_stall <= ($urandom_range(0, 99) < stall_pct);
				end
			end
		end
	end

	// Watchdog: end the run if it never drains.
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("simulation failed");
		$finish;
	end

endmodule
